// ===== rtl/core/adccrs_pkg.sv =====
// Shared types and constants for the ADC channel request scanner.
// Used by adccrs_slot_table and adc_channel_request_scanner; no dependencies.
package adccrs_pkg;

   localparam int SLOT_COUNT    = 6;
   localparam int CHANNEL_COUNT = 8;
   localparam int SAMPLE_BITS   = 10;

   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int FILL_W     = $clog2(SLOT_COUNT + 1);
   localparam int CH_IDX_W   = $clog2(CHANNEL_COUNT);

   typedef logic [2:0]            channel_type;
   typedef logic [9:0]            value_type;
   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [SLOT_IDX_W-1:0] slot_idx_type;
   typedef logic [FILL_W-1:0]     fill_type;
   typedef logic [CH_IDX_W-1:0]   ch_idx_type;

   typedef enum logic {
      CMD_REQUEST = 1'b0,
      CMD_TICK    = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_BUSY = 2'd1,
      PHASE_DONE = 2'd2
   } phase_type;

   typedef struct packed {
      cmd_type     cmd;
      channel_type request_channel;
      logic        converter_idle;
      value_type   converter_sample;
   } req_item_type;

   typedef struct packed {
      logic        start_conversion;
      channel_type conversion_channel;
      logic        result_valid;
      value_type   result_value;
   } rsp_item_type;

endpackage

// ===== rtl/core/adccrs_slot_table.sv =====
// Slot table, sample store and round-robin scan state of the ADC scanner.
// Depends on adccrs_pkg for the item structs, phase codes and sizes.
module adccrs_slot_table (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  adccrs_pkg::req_item_type item,
   output adccrs_pkg::rsp_item_type result
);

   adccrs_pkg::channel_type  slot_channel_ff [adccrs_pkg::SLOT_COUNT];
   adccrs_pkg::channel_type  slot_channel_in [adccrs_pkg::SLOT_COUNT];
   logic                     slot_filled_ff  [adccrs_pkg::SLOT_COUNT];
   logic                     slot_filled_in  [adccrs_pkg::SLOT_COUNT];
   adccrs_pkg::phase_type    slot_phase_ff   [adccrs_pkg::SLOT_COUNT];
   adccrs_pkg::phase_type    slot_phase_in   [adccrs_pkg::SLOT_COUNT];
   adccrs_pkg::sample_type   store_ff        [adccrs_pkg::CHANNEL_COUNT];
   adccrs_pkg::slot_idx_type scan_ff, scan_in;
   logic                     converting_ff, converting_in;
   adccrs_pkg::fill_type     fill_ff, fill_in;

   logic                     store_we;
   adccrs_pkg::ch_idx_type   store_waddr;
   adccrs_pkg::sample_type   store_wdata;

   logic                     found;
   adccrs_pkg::slot_idx_type hit_idx;
   logic                     chan_ok;
   adccrs_pkg::slot_idx_type pos;
   adccrs_pkg::channel_type  pos_channel;

   // Parallel lookup; the lowest matching slot wins.
   always_comb begin
      found   = 1'b0;
      hit_idx = '0;
      for (int i = adccrs_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (slot_filled_ff[i] && (slot_channel_ff[i] == item.request_channel)) begin
            found   = 1'b1;
            hit_idx = adccrs_pkg::slot_idx_type'(i);
         end
      end
   end

   assign chan_ok = (32'(item.request_channel) < 32'(adccrs_pkg::CHANNEL_COUNT));
   assign pos     = (32'(scan_ff) < 32'(adccrs_pkg::SLOT_COUNT)) ? scan_ff : '0;
   assign pos_channel = slot_channel_ff[pos];

   always_comb begin
      slot_channel_in = slot_channel_ff;
      slot_filled_in  = slot_filled_ff;
      slot_phase_in   = slot_phase_ff;
      scan_in         = scan_ff;
      converting_in   = converting_ff;
      fill_in         = fill_ff;
      store_we        = 1'b0;
      store_waddr     = adccrs_pkg::ch_idx_type'(pos_channel);
      store_wdata     = adccrs_pkg::sample_type'(item.converter_sample);
      result          = '0;

      case (item.cmd)
         adccrs_pkg::CMD_REQUEST: begin
            if (chan_ok) begin
               if (found) begin
                  if (slot_phase_ff[hit_idx] == adccrs_pkg::PHASE_DONE) begin
                     result.result_valid = 1'b1;
                     result.result_value = adccrs_pkg::value_type'(
                        store_ff[adccrs_pkg::ch_idx_type'(item.request_channel)]);
                     slot_phase_in[hit_idx] = adccrs_pkg::PHASE_IDLE;
                  end
               end else if (32'(fill_ff) < 32'(adccrs_pkg::SLOT_COUNT)) begin
                  slot_channel_in[fill_ff[adccrs_pkg::SLOT_IDX_W-1:0]] = item.request_channel;
                  slot_filled_in[fill_ff[adccrs_pkg::SLOT_IDX_W-1:0]]  = 1'b1;
                  slot_phase_in[fill_ff[adccrs_pkg::SLOT_IDX_W-1:0]]   = adccrs_pkg::PHASE_IDLE;
                  fill_in = fill_ff + adccrs_pkg::fill_type'(1);
               end
            end
         end
         adccrs_pkg::CMD_TICK: begin
            scan_in = pos;
            if (!converting_ff) begin
               if (slot_filled_ff[pos] && (slot_phase_ff[pos] == adccrs_pkg::PHASE_IDLE)) begin
                  result.start_conversion   = 1'b1;
                  result.conversion_channel = pos_channel;
                  slot_phase_in[pos]        = adccrs_pkg::PHASE_BUSY;
                  converting_in             = 1'b1;
               end else begin
                  scan_in = (32'(pos) == adccrs_pkg::SLOT_COUNT - 1) ? '0
                          : pos + adccrs_pkg::slot_idx_type'(1);
               end
            end else if (item.converter_idle) begin
               if (slot_phase_ff[pos] == adccrs_pkg::PHASE_BUSY) begin
                  store_we           = (32'(pos_channel) < 32'(adccrs_pkg::CHANNEL_COUNT));
                  slot_phase_in[pos] = adccrs_pkg::PHASE_DONE;
                  converting_in      = 1'b0;
                  scan_in = (32'(pos) == adccrs_pkg::SLOT_COUNT - 1) ? '0
                          : pos + adccrs_pkg::slot_idx_type'(1);
               end
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < adccrs_pkg::SLOT_COUNT; i++) begin
            slot_filled_ff[i] <= 1'b0;
            slot_phase_ff[i]  <= adccrs_pkg::PHASE_IDLE;
         end
         scan_ff       <= '0;
         converting_ff <= 1'b0;
         fill_ff       <= '0;
      end else if (step) begin
         slot_filled_ff <= slot_filled_in;
         slot_phase_ff  <= slot_phase_in;
         scan_ff        <= scan_in;
         converting_ff  <= converting_in;
         fill_ff        <= fill_in;
      end
   end

   // Channel numbers and samples have no defined reset value.
   always_ff @(posedge clock) begin
      if (step) begin
         slot_channel_ff <= slot_channel_in;
         if (store_we) begin
            store_ff[store_waddr] <= store_wdata;
         end
      end
   end

endmodule

// ===== rtl/core/adc_channel_request_scanner.sv =====
// Top level of the ADC channel request scanner: request and response registers.
// Depends on adccrs_pkg and adccrs_slot_table.

// The scanner takes one request per clock while responses drain, and returns
// exactly one response for each, through the input and output registers.
// A request registered at the input is resolved against the six-slot table
// and the per-channel sample store, and the response is registered at the
// output. While a finished response waits, the input register can take one
// more request and then holds it until the response is drained; with the
// response side always ready the sustained rate is one request per cycle.
// Channel requests return a stored sample only for a slot in the done phase;
// scan ticks start a conversion or capture the converter's sample.
module adc_channel_request_scanner (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic [2:0] req_request_channel,
   input  logic       req_converter_idle,
   input  logic [9:0] req_converter_sample,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_start_conversion,
   output logic [2:0] rsp_conversion_channel,
   output logic       rsp_result_valid,
   output logic [9:0] rsp_result_value
);

   logic                     in_valid_ff, in_valid_in;
   adccrs_pkg::req_item_type in_item_ff;
   logic                     out_valid_ff, out_valid_in;
   adccrs_pkg::rsp_item_type out_item_ff;
   adccrs_pkg::rsp_item_type result;
   logic                     advance;
   logic                     req_take;

   // A request moves on when the response register is empty or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   adccrs_slot_table u_table (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.cmd              <= adccrs_pkg::cmd_type'(req_cmd);
         in_item_ff.request_channel  <= req_request_channel;
         in_item_ff.converter_idle   <= req_converter_idle;
         in_item_ff.converter_sample <= req_converter_sample;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_start_conversion   = out_item_ff.start_conversion;
   assign rsp_conversion_channel = out_item_ff.conversion_channel;
   assign rsp_result_valid       = out_item_ff.result_valid;
   assign rsp_result_value       = out_item_ff.result_value;

endmodule

// ===== tb/adc_channel_request_scanner_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for adc_channel_request_scanner: drives requests and
// scan ticks, predicts every response and checks it. Depends on adccrs_pkg.
module adc_channel_request_scanner_tb
   import adccrs_pkg::*;
();

   localparam int RUN_ITEMS   = 1900;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_WAIT    = 6;

   // Predicts the scanner's slot table, scan pointer and sample store, and
   // keeps the responses that accepted requests still owe.
   class scan_response_board;
      channel_type  slot_chan [SLOT_COUNT];
      logic         slot_used [SLOT_COUNT];
      phase_type    slot_state[SLOT_COUNT];
      sample_type   samples   [CHANNEL_COUNT];
      slot_idx_type scan_pos;
      fill_type     filled;
      logic         converting;
      rsp_item_type pending_rsp[$];
      int           mismatches;

      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_chan[i]  = '0;
            slot_used[i]  = 1'b0;
            slot_state[i] = PHASE_IDLE;
         end
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            samples[i] = '0;
         end
         scan_pos   = '0;
         filled     = '0;
         converting = 1'b0;
         mismatches = 0;
      endfunction

      function void step_scan();
         if (scan_pos >= SLOT_COUNT - 1) begin
            scan_pos = '0;
         end else begin
            scan_pos = scan_pos + 1'b1;
         end
      endfunction

      function void note_request(req_item_type item);
         rsp_item_type exp;
         int           hit;
         int           p;
         exp = '0;
         if (item.cmd == CMD_REQUEST) begin
            if (item.request_channel < CHANNEL_COUNT) begin
               hit = -1;
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (hit < 0 && slot_used[i] && slot_chan[i] == item.request_channel) begin
                     hit = i;
                  end
               end
               if (hit < 0) begin
                  // A new channel takes the next free slot; a full table drops it.
                  if (filled < SLOT_COUNT) begin
                     slot_chan[filled]  = item.request_channel;
                     slot_used[filled]  = 1'b1;
                     slot_state[filled] = PHASE_IDLE;
                     filled = filled + 1'b1;
                  end
               end else if (slot_state[hit] == PHASE_DONE) begin
                  exp.result_valid = 1'b1;
                  exp.result_value = value_type'(samples[item.request_channel]);
                  slot_state[hit]  = PHASE_IDLE;
               end
            end
         end else begin
            p = scan_pos;
            if (p >= SLOT_COUNT) begin
               p = 0;
               scan_pos = '0;
            end
            if (!converting) begin
               if (slot_used[p] && slot_state[p] == PHASE_IDLE) begin
                  exp.start_conversion   = 1'b1;
                  exp.conversion_channel = slot_chan[p];
                  slot_state[p] = PHASE_BUSY;
                  converting    = 1'b1;
               end else begin
                  step_scan();
               end
            end else if (item.converter_idle && slot_state[p] == PHASE_BUSY) begin
               if (slot_chan[p] < CHANNEL_COUNT) begin
                  samples[slot_chan[p]] = item.converter_sample[SAMPLE_BITS-1:0];
               end
               slot_state[p] = PHASE_DONE;
               converting    = 1'b0;
               step_scan();
            end
         end
         pending_rsp.push_back(exp);
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type exp;
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with no request outstanding: start %0b chan %0d valid %0b value %0d",
                     $time, got.start_conversion, got.conversion_channel,
                     got.result_valid, got.result_value);
            mismatches++;
         end else begin
            exp = pending_rsp.pop_front();
            if (got.start_conversion !== exp.start_conversion) begin
               $display("%0t: start_conversion expected %0b actual %0b",
                        $time, exp.start_conversion, got.start_conversion);
               mismatches++;
            end
            if (got.conversion_channel !== exp.conversion_channel) begin
               $display("%0t: conversion_channel expected %0d actual %0d",
                        $time, exp.conversion_channel, got.conversion_channel);
               mismatches++;
            end
            if (got.result_valid !== exp.result_valid) begin
               $display("%0t: result_valid expected %0b actual %0b",
                        $time, exp.result_valid, got.result_valid);
               mismatches++;
            end
            if (got.result_value !== exp.result_value) begin
               $display("%0t: result_value expected %0d actual %0d",
                        $time, exp.result_value, got.result_value);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_cmd = 1'b0;
   logic [2:0] req_request_channel = '0;
   logic       req_converter_idle = 1'b0;
   logic [9:0] req_converter_sample = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_start_conversion;
   logic [2:0] rsp_conversion_channel;
   logic       rsp_result_valid;
   logic [9:0] rsp_result_value;

   scan_response_board board;
   bit  req_calm = 1'b0;
   bit  rsp_calm = 1'b0;
   int  cycles = 0;

   adc_channel_request_scanner u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_cmd                (req_cmd),
      .req_request_channel    (req_request_channel),
      .req_converter_idle     (req_converter_idle),
      .req_converter_sample   (req_converter_sample),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_start_conversion   (rsp_start_conversion),
      .rsp_conversion_channel (rsp_conversion_channel),
      .rsp_result_valid       (rsp_result_valid),
      .rsp_result_value       (rsp_result_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         board.note_request(req_item_type'{cmd_type'(req_cmd), req_request_channel,
                                           req_converter_idle, req_converter_sample});
      end
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_response(rsp_item_type'{rsp_start_conversion, rsp_conversion_channel,
                                             rsp_result_valid, rsp_result_value});
      end
   end

   // Called at a rising edge; returns at the edge where the request is taken.
   task send_request(input cmd_type cmd, input channel_type chan, input logic idle,
                     input value_type sample);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_cmd              <= cmd;
      req_request_channel  <= chan;
      req_converter_idle   <= idle;
      req_converter_sample <= sample;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      cmd_type cmd;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // One full conversion on channel 7, including a tick while the
      // converter is still running, then a read and a read of an idle slot.
      send_request(CMD_REQUEST, 3'd7, 1'b0, 10'd0);
      send_request(CMD_TICK,    3'd0, 1'b0, 10'd0);
      send_request(CMD_TICK,    3'd0, 1'b0, 10'd0);
      send_request(CMD_TICK,    3'd0, 1'b1, 10'h3ff);
      send_request(CMD_REQUEST, 3'd7, 1'b0, 10'd0);
      send_request(CMD_REQUEST, 3'd7, 1'b0, 10'd0);
      // Fill the table; channels 5 and 6 find it full and are dropped.
      for (int ch = 0; ch < 7; ch++) begin
         send_request(CMD_REQUEST, channel_type'(ch), 1'b0, 10'd0);
      end
      send_request(CMD_TICK,    3'd7, 1'b1, 10'h155);
      send_request(CMD_REQUEST, 3'd0, 1'b0, 10'd0);
      send_request(CMD_TICK,    3'd5, 1'b1, 10'd0);
      send_request(CMD_REQUEST, 3'd0, 1'b0, 10'd0);
      // Walk the remaining slots so the scan pointer wraps back to slot 0.
      for (int i = 0; i < 9; i++) begin
         send_request(CMD_TICK, channel_type'(i), 1'b1, (i % 2) ? 10'h2aa : 10'h155);
      end

      for (int n = 0; n < RUN_ITEMS; n++) begin
         if (n % 100 == 0) begin
            req_calm = ($urandom_range(0, 3) == 0);
            rsp_calm = ($urandom_range(0, 3) == 0);
         end
         cmd = ($urandom_range(0, 99) < 55) ? CMD_TICK : CMD_REQUEST;
         send_request(cmd, channel_type'($urandom_range(0, 7)),
                      logic'($urandom_range(0, 9) < 6), value_type'($urandom_range(0, 1023)));
      end
      req_valid <= 1'b0;

      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
